@@ hw/rtl/xsag_pkg.sv @@
`default_nettype none

package xsag_pkg;

    localparam int unsigned WORD_W            = 64;
    localparam int unsigned LEN_W             = 7;
    localparam int unsigned BYTE_W            = 8;
    localparam int unsigned BYTES_PER_WORD    = WORD_W / BYTE_W;
    localparam int unsigned BYTE_IDX_W        = $clog2(BYTES_PER_WORD);
    localparam int unsigned CFG_INDEX_W       = 2;
    localparam int unsigned MAX_STRING_LENGTH = 64;

    localparam int unsigned SHIFT_A_LEFT  = 23;
    localparam int unsigned SHIFT_S_RIGHT = 17;
    localparam int unsigned SHIFT_B_RIGHT = 26;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEED_A = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEED_B = 2'd1;

    localparam logic OP_WORD   = 1'b0;
    localparam logic OP_STRING = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADV,
        ST_SCAN,
        ST_STUCK
    } state_t;

    // True for an ASCII digit or an upper or lower case letter.
    function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
        logic digit;
        logic upper;
        logic lower;
        digit = (c >= 8'h30) && (c <= 8'h39);
        upper = (c >= 8'h41) && (c <= 8'h5A);
        lower = (c >= 8'h61) && (c <= 8'h7A);
        return digit || upper || lower;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/xsag_req_if.sv @@
`default_nettype none

interface xsag_req_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [xsag_pkg::LEN_W-1:0] length;

    modport source (output valid, output opcode, output length, input ready);
    modport sink   (input valid, input opcode, input length, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/xsag_res_if.sv @@
`default_nettype none

interface xsag_res_if;
    logic                        valid;
    logic                        ready;
    logic [xsag_pkg::WORD_W-1:0] value;
    logic                        last;
    logic                        stuck_error;

    modport source (output valid, output value, output last, output stuck_error,
                    input ready);
    modport sink   (input valid, input value, input last, input stuck_error,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/xorshift128plus_alnum_generator_top.sv @@
`default_nettype none

// xorshift128+ generator with an alphanumeric string mode. A write to either
// seed register loads both generator words from both seed registers. A request
// with opcode 0 advances the generator once and returns the 64-bit sum as a
// single result marked last; the advance step waits, if need be, for the
// result register to drain. A request with opcode 1 and a length N
// (saturated to 64) returns N ASCII letters or digits, one per result in the
// low byte of value, the final one marked last. Each generated word takes an
// advance step and then a scan of its bytes from the low end, one at a
// time through a single byte shifter and classifier; a letter or digit waits
// there for the output register, so the time that a string takes is data
// dependent. A zero length returns nothing; an all-zero generator state in
// string mode returns one result with stuck_error set and leaves the state
// alone. New requests are taken only while the sequencer is idle, but a
// finished result may still be waiting in the output register at that time.

module xorshift128plus_alnum_generator_top (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_we,
    input  wire  [xsag_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [xsag_pkg::WORD_W-1:0]           cfg_wdata,
    xsag_req_if.sink                              req,
    xsag_res_if.source                            res
);

    xsag_pkg::state_t state_reg, state_next;

    logic [xsag_pkg::WORD_W-1:0]     seed_a_reg, seed_a_next;
    logic [xsag_pkg::WORD_W-1:0]     seed_b_reg, seed_b_next;
    logic [xsag_pkg::WORD_W-1:0]     gen_a_reg, gen_a_next;
    logic [xsag_pkg::WORD_W-1:0]     gen_b_reg, gen_b_next;
    logic [xsag_pkg::WORD_W-1:0]     word_reg, word_next;
    logic [xsag_pkg::BYTE_IDX_W-1:0] idx_reg, idx_next;
    logic [xsag_pkg::LEN_W-1:0]      want_reg, want_next;
    logic [xsag_pkg::LEN_W-1:0]      count_reg, count_next;
    logic                            mode_reg, mode_next;

    logic                            out_valid_reg, out_valid_next;
    logic [xsag_pkg::WORD_W-1:0]     out_value_reg, out_value_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_stuck_reg, out_stuck_next;

    logic                            req_acc;
    logic                            out_free;
    logic                            gen_zero;
    logic [xsag_pkg::WORD_W-1:0]     s1;
    logic [xsag_pkg::WORD_W-1:0]     adv_b;
    logic [xsag_pkg::WORD_W-1:0]     adv_sum;
    logic [xsag_pkg::BYTE_W-1:0]     cur_byte;
    logic                            cur_alnum;
    logic [xsag_pkg::LEN_W-1:0]      count_inc;
    logic                            is_final;
    logic [xsag_pkg::LEN_W-1:0]      length_sat;

    assign req.ready   = (state_reg == xsag_pkg::ST_IDLE);
    assign req_acc     = req.valid && req.ready;
    assign res.valid   = out_valid_reg;
    assign res.value   = out_value_reg;
    assign res.last    = out_last_reg;
    assign res.stuck_error = out_stuck_reg;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || res.ready;
    assign gen_zero = (gen_a_reg == '0) && (gen_b_reg == '0);

    // One advance of the generator: shifts and XORs, then the single wide add.
    assign s1      = gen_a_reg ^ (gen_a_reg << xsag_pkg::SHIFT_A_LEFT);
    assign adv_b   = s1 ^ gen_b_reg ^ (s1 >> xsag_pkg::SHIFT_S_RIGHT)
                     ^ (gen_b_reg >> xsag_pkg::SHIFT_B_RIGHT);
    assign adv_sum = adv_b + gen_b_reg;

    // The scan word shifts down a byte per cycle when not stalled, so the low byte is current.
    assign cur_byte  = word_reg[xsag_pkg::BYTE_W-1:0];
    assign cur_alnum = xsag_pkg::is_alnum(cur_byte);
    assign count_inc = count_reg + 1'b1;
    assign is_final  = (count_inc == want_reg);

    assign length_sat = (req.length > xsag_pkg::LEN_W'(xsag_pkg::MAX_STRING_LENGTH))
                        ? xsag_pkg::LEN_W'(xsag_pkg::MAX_STRING_LENGTH) : req.length;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            xsag_pkg::ST_IDLE:
            begin
                if (req_acc)
                begin
                    if (req.opcode == xsag_pkg::OP_WORD)
                        state_next = xsag_pkg::ST_ADV;
                    else if (req.length == '0)
                        state_next = xsag_pkg::ST_IDLE;
                    else if (gen_zero)
                        state_next = xsag_pkg::ST_STUCK;
                    else
                        state_next = xsag_pkg::ST_ADV;
                end
            end
            xsag_pkg::ST_ADV:
            begin
                if (mode_reg == xsag_pkg::OP_WORD)
                begin
                    if (out_free)
                        state_next = xsag_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = xsag_pkg::ST_SCAN;
                end
            end
            xsag_pkg::ST_SCAN:
            begin
                if (cur_alnum && out_free && is_final)
                    state_next = xsag_pkg::ST_IDLE;
                else if ((!cur_alnum || out_free) && (idx_reg == '1))
                    state_next = xsag_pkg::ST_ADV;
            end
            xsag_pkg::ST_STUCK:
            begin
                if (out_free)
                    state_next = xsag_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = xsag_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates for each sequencer step.
    always_comb
    begin
        seed_a_next    = seed_a_reg;
        seed_b_next    = seed_b_reg;
        gen_a_next     = gen_a_reg;
        gen_b_next     = gen_b_reg;
        word_next      = word_reg;
        idx_next       = idx_reg;
        want_next      = want_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_stuck_next = out_stuck_reg;

        case (state_reg)
            xsag_pkg::ST_IDLE:
            begin
                if (req_acc)
                begin
                    mode_next  = req.opcode;
                    want_next  = length_sat;
                    count_next = '0;
                end
            end
            xsag_pkg::ST_ADV:
            begin
                if (mode_reg == xsag_pkg::OP_WORD)
                begin
                    if (out_free)
                    begin
                        gen_a_next     = gen_b_reg;
                        gen_b_next     = adv_b;
                        out_valid_next = 1'b1;
                        out_value_next = adv_sum;
                        out_last_next  = 1'b1;
                        out_stuck_next = 1'b0;
                    end
                end
                else
                begin
                    gen_a_next = gen_b_reg;
                    gen_b_next = adv_b;
                    word_next  = adv_sum;
                    idx_next   = '0;
                end
            end
            xsag_pkg::ST_SCAN:
            begin
                if (!cur_alnum || out_free)
                begin
                    word_next = word_reg >> xsag_pkg::BYTE_W;
                    idx_next  = idx_reg + 1'b1;
                end
                if (cur_alnum && out_free)
                begin
                    count_next     = count_inc;
                    out_valid_next = 1'b1;
                    out_value_next = xsag_pkg::WORD_W'(cur_byte);
                    out_last_next  = is_final;
                    out_stuck_next = 1'b0;
                end
            end
            xsag_pkg::ST_STUCK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    out_last_next  = 1'b1;
                    out_stuck_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Seed writes must arrive only while idle, which the block does not enforce; either one reloads both words.
        if (cfg_we && ((cfg_index == xsag_pkg::CFG_SEED_A) ||
                       (cfg_index == xsag_pkg::CFG_SEED_B)))
        begin
            if (cfg_index == xsag_pkg::CFG_SEED_A)
                seed_a_next = cfg_wdata;
            else
                seed_b_next = cfg_wdata;
            gen_a_next = (cfg_index == xsag_pkg::CFG_SEED_A) ? cfg_wdata : seed_a_reg;
            gen_b_next = (cfg_index == xsag_pkg::CFG_SEED_B) ? cfg_wdata : seed_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xsag_pkg::ST_IDLE;
            seed_a_reg    <= '0;
            seed_b_reg    <= '0;
            gen_a_reg     <= '0;
            gen_b_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            count_reg     <= '0;
            want_reg      <= '0;
            mode_reg      <= xsag_pkg::OP_WORD;
        end
        else
        begin
            state_reg     <= state_next;
            seed_a_reg    <= seed_a_next;
            seed_b_reg    <= seed_b_next;
            gen_a_reg     <= gen_a_next;
            gen_b_reg     <= gen_b_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            want_reg      <= want_next;
            mode_reg      <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_stuck_reg <= out_stuck_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/xsag_checker.sv @@
`default_nettype none

module xsag_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          req_ready,
    input wire                          res_valid,
    input wire                          res_ready,
    input wire [xsag_pkg::WORD_W-1:0]   res_value,
    input wire                          res_last,
    input wire                          res_stuck_error
);

    // A stalled result holds its contents.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_value)
            && $stable(res_last) && $stable(res_stuck_error))
        else $error("result changed while stalled");

    // The stuck report is a lone, zero, final result.
    a_stuck_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stuck_error |-> res_last && (res_value == '0))
        else $error("malformed stuck result");

    // Only string bytes come without last, and they fit in a byte.
    a_byte_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> (res_value[xsag_pkg::WORD_W-1:xsag_pkg::BYTE_W] == '0)
            && xsag_pkg::is_alnum(res_value[xsag_pkg::BYTE_W-1:0]) && !res_stuck_error)
        else $error("string result not an alphanumeric byte");

    // Part way through a string no new request is taken.
    a_busy_mid_string: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> !req_ready)
        else $error("request taken while a string is still running");

endmodule

bind xorshift128plus_alnum_generator_top xsag_checker u_xsag_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ready       (req.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_value       (res.value),
    .res_last        (res.last),
    .res_stuck_error (res.stuck_error)
);

`default_nettype wire

@@ dv/tb_xorshift128plus_alnum_generator_top.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the xorshift128+ generator with its alphanumeric
// string mode. A small model of the generator is kept here: it follows every
// seed write and every accepted request, and queues the results that the block
// should return. Each returned result is compared with the oldest queued one.
// The directed tests cover the all-zero state, the seed loading rules and the
// string lengths. The random test then runs several idling phases, reseeding
// between bursts of requests.

module tb_xorshift128plus_alnum_generator_top;

    // Register indexes that the block does not decode; writes must be ignored.
    localparam logic [xsag_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [xsag_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    // Cycles allowed for the block to settle after the last expected result,
    // covering a zero-length string request that produces nothing.
    localparam int unsigned SETTLE_CYCLES = 32;

    typedef struct packed {
        logic [xsag_pkg::WORD_W-1:0] value;
        logic                        last;
        logic                        stuck_error;
    } gen_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [xsag_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [xsag_pkg::WORD_W-1:0]      cfg_wdata;

    xsag_req_if req_ch ();
    xsag_res_if res_ch ();

    xorshift128plus_alnum_generator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .res       (res_ch)
    );

    // Period of 12 ns.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Our own copy of the seed registers and the generator words.
    logic [xsag_pkg::WORD_W-1:0] seed_a;
    logic [xsag_pkg::WORD_W-1:0] seed_b;
    logic [xsag_pkg::WORD_W-1:0] gen_a;
    logic [xsag_pkg::WORD_W-1:0] gen_b;

    gen_result_t pending_results[$];
    int unsigned mismatch_count = 0;

    // Percentages of cycles in which the sender holds back or the receiver stalls.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // One xorshift128+ step: moves the generator on and returns the sum.
    function automatic logic [xsag_pkg::WORD_W-1:0] advance_generator();
        logic [xsag_pkg::WORD_W-1:0] s1;
        logic [xsag_pkg::WORD_W-1:0] s0;
        s1 = gen_a;
        s0 = gen_b;
        gen_a = s0;
        s1 = s1 ^ (s1 << xsag_pkg::SHIFT_A_LEFT);
        gen_b = s1 ^ s0 ^ (s1 >> xsag_pkg::SHIFT_S_RIGHT) ^ (s0 >> xsag_pkg::SHIFT_B_RIGHT);
        return gen_b + s0;
    endfunction

    function automatic bit letter_or_digit(input logic [xsag_pkg::BYTE_W-1:0] c);
        return (c inside {[8'h30 : 8'h39], [8'h41 : 8'h5A], [8'h61 : 8'h7A]});
    endfunction

    // Works out the results of one accepted request and queues them.
    function automatic void queue_request_results(input logic op,
                                                  input logic [xsag_pkg::LEN_W-1:0] len);
        gen_result_t                 r;
        logic [xsag_pkg::WORD_W-1:0] word;
        logic [xsag_pkg::BYTE_W-1:0] c;
        int unsigned                 want;
        int unsigned                 count;
        if (op == xsag_pkg::OP_WORD)
        begin
            r.value = advance_generator();
            r.last = 1'b1;
            r.stuck_error = 1'b0;
            pending_results.push_back(r);
            return;
        end
        want = len;
        if (want == 0)
            return;
        if (want > xsag_pkg::MAX_STRING_LENGTH)
            want = xsag_pkg::MAX_STRING_LENGTH;
        // A zero state can never leave zero, so the block flags it instead.
        if (gen_a == '0 && gen_b == '0)
        begin
            r.value = '0;
            r.last = 1'b1;
            r.stuck_error = 1'b1;
            pending_results.push_back(r);
            return;
        end
        count = 0;
        while (count < want)
        begin
            word = advance_generator();
            for (int i = 0; i < xsag_pkg::BYTES_PER_WORD && count < want; i++)
            begin
                c = word[i*xsag_pkg::BYTE_W +: xsag_pkg::BYTE_W];
                if (letter_or_digit(c))
                begin
                    count++;
                    r.value = {{(xsag_pkg::WORD_W-xsag_pkg::BYTE_W){1'b0}}, c};
                    r.last = (count == want);
                    r.stuck_error = 1'b0;
                    pending_results.push_back(r);
                end
            end
        end
    endfunction

    // Writes one register. Either seed write reloads both generator words.
    task automatic write_register(input logic [xsag_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [xsag_pkg::WORD_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == xsag_pkg::CFG_SEED_A || idx == xsag_pkg::CFG_SEED_B)
        begin
            if (idx == xsag_pkg::CFG_SEED_A)
                seed_a = data;
            else
                seed_b = data;
            gen_a = seed_a;
            gen_b = seed_b;
        end
        @(posedge clk);
    endtask

    task automatic load_seeds(input logic [xsag_pkg::WORD_W-1:0] a,
                              input logic [xsag_pkg::WORD_W-1:0] b);
        write_register(xsag_pkg::CFG_SEED_A, a);
        write_register(xsag_pkg::CFG_SEED_B, b);
    endtask

    // Presents one request and returns at the edge where it is taken. The
    // valid line is left high so that the next request can follow at once.
    task automatic send_request(input logic op, input logic [xsag_pkg::LEN_W-1:0] len);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.length <= len;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        queue_request_results(op, len);
    endtask

    // Drops valid, waits for every expected result and lets the block settle,
    // so that a register write cannot land while a request is in flight.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: stalls at random according to the current phase.
    always @(posedge clk)
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        gen_result_t exp_r;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: value %h last %b stuck_error %b",
                       res_ch.value, res_ch.last, res_ch.stuck_error);
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (res_ch.value !== exp_r.value)
                begin
                    $error("value: expected %h, got %h", exp_r.value, res_ch.value);
                    mismatch_count++;
                end
                if (res_ch.last !== exp_r.last)
                begin
                    $error("last: expected %b, got %b", exp_r.last, res_ch.last);
                    mismatch_count++;
                end
                if (res_ch.stuck_error !== exp_r.stuck_error)
                begin
                    $error("stuck_error: expected %b, got %b",
                           exp_r.stuck_error, res_ch.stuck_error);
                    mismatch_count++;
                end
            end
        end
    end

    // After reset the generator is all zero: a word request simply returns
    // zero, a string request is flagged as stuck and a zero length returns
    // nothing at all.
    task automatic test_zero_state();
        send_request(xsag_pkg::OP_WORD, '0);
        send_request(xsag_pkg::OP_STRING, 7'd5);
        send_request(xsag_pkg::OP_STRING, 7'd0);
        send_request(xsag_pkg::OP_WORD, 7'd127);
        send_request(xsag_pkg::OP_STRING, 7'd127);
        drain_results();
    endtask

    // Seed loading: extreme seeds, one word zero with the other set, and
    // writes to the undecoded indexes, which must leave the state untouched.
    task automatic test_seed_loading();
        load_seeds('1, '1);
        send_request(xsag_pkg::OP_WORD, 7'd1);
        send_request(xsag_pkg::OP_STRING, 7'd3);
        drain_results();
        write_register(xsag_pkg::CFG_SEED_A, '0);
        send_request(xsag_pkg::OP_WORD, 7'd64);
        send_request(xsag_pkg::OP_STRING, 7'd2);
        drain_results();
        load_seeds(64'd1, '0);
        write_register(CFG_SPARE_2, '1);
        write_register(CFG_SPARE_3, 64'h0123_4567_89AB_CDEF);
        send_request(xsag_pkg::OP_WORD, '0);
        send_request(xsag_pkg::OP_STRING, 7'd4);
        drain_results();
    endtask

    // String lengths: the shortest, the largest allowed, and values above it,
    // which the block saturates; every length bit is exercised.
    task automatic test_string_lengths();
        load_seeds(64'h9E37_79B9_7F4A_7C15, 64'hBF58_476D_1CE4_E5B9);
        send_request(xsag_pkg::OP_STRING, 7'd1);
        send_request(xsag_pkg::OP_STRING, 7'd64);
        send_request(xsag_pkg::OP_STRING, 7'd65);
        send_request(xsag_pkg::OP_STRING, 7'd127);
        send_request(xsag_pkg::OP_STRING, 7'd0);
        send_request(xsag_pkg::OP_WORD, 7'd0);
        send_request(xsag_pkg::OP_STRING, 7'd42);
        send_request(xsag_pkg::OP_STRING, 7'd21);
        drain_results();
    endtask

    // Picks a length: mostly short strings to keep the run brisk, with the
    // occasional zero, long or over-long one.
    function automatic logic [xsag_pkg::LEN_W-1:0] pick_length();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return '0;
        else if (sel < 70)
            return xsag_pkg::LEN_W'($urandom_range(1, 16));
        else if (sel < 88)
            return xsag_pkg::LEN_W'($urandom_range(17, xsag_pkg::MAX_STRING_LENGTH));
        else
            return xsag_pkg::LEN_W'($urandom_range(xsag_pkg::MAX_STRING_LENGTH + 1, 127));
    endfunction

    // Random reseed between bursts. Now and then the state is set to all zero
    // or all ones, or only one register is written, or a spare index is hit.
    task automatic reseed_random();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: load_seeds('0, '0);
            1: load_seeds('1, '1);
            2: write_register(xsag_pkg::CFG_SEED_A, {$urandom, $urandom});
            3: write_register(xsag_pkg::CFG_SEED_B, {$urandom, $urandom});
            4:
            begin
                write_register($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                               {$urandom, $urandom});
                load_seeds({$urandom, $urandom}, {$urandom, $urandom});
            end
            default: load_seeds({$urandom, $urandom}, {$urandom, $urandom});
        endcase
    endtask

    // One idling phase of random traffic, reseeded every few dozen requests.
    task automatic test_random_traffic(input int unsigned send_pct,
                                       input int unsigned recv_pct,
                                       input int unsigned n_requests);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int unsigned n = 0; n < n_requests; n++)
        begin
            if (n % 25 == 0)
            begin
                drain_results();
                reseed_random();
            end
            send_request(1'($urandom_range(0, 1)), pick_length());
        end
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.opcode = xsag_pkg::OP_WORD;
        req_ch.length = '0;
        seed_a = '0;
        seed_b = '0;
        gen_a = '0;
        gen_b = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_state();
        test_seed_loading();
        test_string_lengths();

        // No idling, a slow sender, a slow receiver, then both at once.
        test_random_traffic(0, 0, 75);
        test_random_traffic(86, 0, 75);
        test_random_traffic(0, 86, 75);
        test_random_traffic(33, 33, 75);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #60ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
